FILE: hdl/point_in_triangle_table_unit_macros.svh
// Assertion macros used by the point-in-triangle table checker.
`ifndef POINT_IN_TRIANGLE_TABLE_UNIT_MACROS_SVH
`define POINT_IN_TRIANGLE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define PITT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point_in_triangle_table_unit check failed");

// Next-cycle implication, sampled on clk and ignored while rst_n is low.
`define PITT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point_in_triangle_table_unit check failed");

`endif

FILE: hdl/pitt_pkg.sv
// Types, widths and helpers shared by the point-in-triangle table unit.
`default_nettype none

package pitt_pkg;

  localparam int PITT_TRI_COUNT   = 1024;
  localparam int PITT_QUEUE_DEPTH = 2;

  localparam int COORD_W = 24;
  localparam int INDEX_W = 10;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int GAMMA_W = DIFF_W + 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [GAMMA_W-1:0] gamma_t;

  typedef struct packed {
    logic               operation;
    logic [INDEX_W-1:0] tri_index;
    coord_t             vert_a_x;
    coord_t             vert_a_y;
    coord_t             vert_b_x;
    coord_t             vert_b_y;
    coord_t             vert_c_x;
    coord_t             vert_c_y;
    coord_t             point_x;
    coord_t             point_y;
  } in_word_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_MISS
  } cmd_kind_t;

  // Classified word in the queue. For a load p holds vertex a, for a query the point.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [INDEX_W-1:0] tri_index;
    coord_t             p_x;
    coord_t             p_y;
    edge_t              u_x;
    edge_t              u_y;
    edge_t              v_x;
    edge_t              v_y;
  } cmd_t;

  typedef struct packed {
    coord_t org_x;
    coord_t org_y;
    edge_t  u_x;
    edge_t  u_y;
    edge_t  v_x;
    edge_t  v_y;
  } tri_entry_t;

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pitt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pitt_ram
  import pitt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [addr_bits(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       rd_en,
  input  wire logic [addr_bits(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pitt_front.sv
// Front end: takes input words, classifies them and forms the edge vectors of loads.
`default_nettype none

module pitt_front
  import pitt_pkg::*;
#(
  parameter int TRI_COUNT = PITT_TRI_COUNT
) (
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output cmd_t          q_data
);

  always_comb begin
    in_ready = !q_full;
    q_push   = in_valid && !q_full;

    q_data.tri_index = in_data.tri_index;
    q_data.u_x = edge_t'(in_data.vert_b_x) - edge_t'(in_data.vert_a_x);
    q_data.u_y = edge_t'(in_data.vert_b_y) - edge_t'(in_data.vert_a_y);
    q_data.v_x = edge_t'(in_data.vert_c_x) - edge_t'(in_data.vert_a_x);
    q_data.v_y = edge_t'(in_data.vert_c_y) - edge_t'(in_data.vert_a_y);

    unique case (in_data.operation)
      OP_LOAD: begin
        q_data.kind = CMD_LOAD;
        q_data.p_x  = in_data.vert_a_x;
        q_data.p_y  = in_data.vert_a_y;
      end
      OP_QUERY: begin
        q_data.kind = CMD_QUERY;
        q_data.p_x  = in_data.point_x;
        q_data.p_y  = in_data.point_y;
      end
      default: begin
        q_data.kind = CMD_MISS;
        q_data.p_x  = in_data.point_x;
        q_data.p_y  = in_data.point_y;
      end
    endcase

    // An index past the table is answered without touching it.
    if (int'(in_data.tri_index) >= TRI_COUNT) begin
      q_data.kind = CMD_MISS;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pitt_fifo.sv
// Short queue of classified words between the front end and the back end.
`default_nettype none

module pitt_fifo
  import pitt_pkg::*;
#(
  parameter int DEPTH = PITT_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      not_empty
);

  localparam int PW = addr_bits(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_ok, pop_ok;

  always_comb begin
    full      = (count_r == CW'(DEPTH));
    not_empty = (count_r != '0);
    pop_data  = slot_r[rd_ptr_r];
    push_ok   = push && !full;
    pop_ok    = pop && not_empty;

    wr_ptr_nxt = wr_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    rd_ptr_nxt = rd_ptr_r;
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pitt_back.sv
// Back end: writes loads to the triangle table and runs the sign test for queries.
`default_nettype none

module pitt_back
  import pitt_pkg::*;
#(
  parameter int TRI_COUNT = PITT_TRI_COUNT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  input  wire cmd_t                           q_data,
  output logic                                q_pop,
  output logic                                ram_wr_en,
  output logic [addr_bits(TRI_COUNT)-1:0]     ram_addr,
  output tri_entry_t                          ram_wr_data,
  output logic                                ram_rd_en,
  input  wire logic [$bits(tri_entry_t)-1:0]  ram_rd_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output out_word_t                           out_data
);

  localparam int AW = addr_bits(TRI_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_DIFF,
    S_SIGN,
    S_OUT
  } state_t;

  state_t     state_r;
  logic       out_valid_r;
  out_word_t  out_data_r;
  coord_t     pt_x_r, pt_y_r;
  edge_t      d_x_r, d_y_r;
  prod_t      uxvy_r, uyvx_r, vydx_r, vxdy_r, uxdy_r, uydx_r;
  diff_t      det_r, ca_r, cb_r;
  tri_entry_t rd_entry;
  gamma_t     cg;
  logic       det_zero, ca_ok, cb_ok, cg_ok;

  always_comb begin
    rd_entry  = tri_entry_t'(ram_rd_data);
    q_pop     = (state_r == S_IDLE) && q_valid;
    ram_wr_en = q_pop && (q_data.kind == CMD_LOAD);
    ram_rd_en = q_pop && (q_data.kind == CMD_QUERY);
    ram_addr  = AW'(q_data.tri_index);
    ram_wr_data = '{org_x: q_data.p_x, org_y: q_data.p_y,
                    u_x: q_data.u_x, u_y: q_data.u_y,
                    v_x: q_data.v_x, v_y: q_data.v_y};

    // Each coefficient scaled by det passes when it is zero or shares det's sign.
    cg       = gamma_t'(det_r) - gamma_t'(ca_r) - gamma_t'(cb_r);
    det_zero = (det_r == '0);
    ca_ok    = (ca_r == '0) || (ca_r[DIFF_W-1] == det_r[DIFF_W-1]);
    cb_ok    = (cb_r == '0) || (cb_r[DIFF_W-1] == det_r[DIFF_W-1]);
    cg_ok    = (cg == '0) || (cg[GAMMA_W-1] == det_r[DIFF_W-1]);

    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            pt_x_r <= q_data.p_x;
            pt_y_r <= q_data.p_y;
            if (q_data.kind == CMD_QUERY) begin
              state_r <= S_FETCH;
            end else begin
              out_data_r  <= '0;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end
          end
        end
        S_FETCH: begin
          d_x_r   <= edge_t'(pt_x_r) - edge_t'(rd_entry.org_x);
          d_y_r   <= edge_t'(pt_y_r) - edge_t'(rd_entry.org_y);
          state_r <= S_MUL;
        end
        S_MUL: begin
          uxvy_r  <= rd_entry.u_x * rd_entry.v_y;
          uyvx_r  <= rd_entry.u_y * rd_entry.v_x;
          vydx_r  <= rd_entry.v_y * d_x_r;
          vxdy_r  <= rd_entry.v_x * d_y_r;
          uxdy_r  <= rd_entry.u_x * d_y_r;
          uydx_r  <= rd_entry.u_y * d_x_r;
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          det_r   <= diff_t'(uxvy_r) - diff_t'(uyvx_r);
          ca_r    <= diff_t'(vydx_r) - diff_t'(vxdy_r);
          cb_r    <= diff_t'(uxdy_r) - diff_t'(uydx_r);
          state_r <= S_SIGN;
        end
        S_SIGN: begin
          out_data_r.degenerate <= det_zero;
          out_data_r.inside_res <= !det_zero && ca_ok && cb_ok && cg_ok;
          out_valid_r           <= 1'b1;
          state_r               <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/point_in_triangle_table_unit.sv
// Top level of the point-in-triangle table unit.
//
//   Channel  Direction  Word         Handshake
//   in_      input      in_word_t    in_valid / in_ready
//   out_     output     out_word_t   out_valid / out_ready
//
// Every input word gives exactly one result word, in order.
// A load or an out-of-range index goes straight to its result in the back end; a query
// passes through table read, difference to the origin, six multiplies, three differences, sign test.
// The front end keeps accepting into the queue while the back end works or
// while a result waits on out_ready; in_ready falls only when the queue is full.
// Synchronous active-low reset clears the control state; the triangle table has
// no clearing pass and an entry holds nothing meaningful until it is loaded.
`default_nettype none

module point_in_triangle_table_unit
  import pitt_pkg::*;
#(
  parameter int TRI_COUNT   = PITT_TRI_COUNT,
  parameter int QUEUE_DEPTH = PITT_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int AW = addr_bits(TRI_COUNT);
  localparam int EW = $bits(tri_entry_t);

  logic          q_full, q_push, q_pop, q_valid;
  cmd_t          q_wr_data, q_rd_data;
  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_addr;
  tri_entry_t    ram_wr_data;
  logic [EW-1:0] ram_rd_data;

  pitt_front #(
    .TRI_COUNT(TRI_COUNT)
  ) u_front (
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  pitt_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wr_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rd_data),
    .not_empty(q_valid)
  );

  pitt_back #(
    .TRI_COUNT(TRI_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_rd_data),
    .q_pop      (q_pop),
    .ram_wr_en  (ram_wr_en),
    .ram_addr   (ram_addr),
    .ram_wr_data(ram_wr_data),
    .ram_rd_en  (ram_rd_en),
    .ram_rd_data(ram_rd_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  pitt_ram #(
    .WIDTH(EW),
    .DEPTH(TRI_COUNT)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_addr),
    .wr_data(EW'(ram_wr_data)),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_addr),
    .rd_data(ram_rd_data)
  );

endmodule

`default_nettype wire

FILE: hdl/pitt_checker.sv
// Port-level checker for the point-in-triangle table unit, bound to the top level.
`default_nettype none

`include "point_in_triangle_table_unit_macros.svh"

module pitt_checker
  import pitt_pkg::*;
#(
  parameter int QUEUE_DEPTH = PITT_QUEUE_DEPTH
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 2) + 1;

  // Words accepted whose result has not yet been taken.
  logic [CW-1:0] pend_r, pend_nxt;

  always_comb begin
    pend_nxt = pend_r + CW'(in_valid && in_ready) - CW'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `PITT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `PITT_ASSERT_NOW(a_flags_excl, out_valid, !(out_data.inside_res && out_data.degenerate))
  `PITT_ASSERT_NOW(a_no_orphan, out_valid, pend_r != '0)
  `PITT_ASSERT_NOW(a_stall_busy, !in_ready, pend_r != '0)
  `PITT_ASSERT_NOW(a_pend_bound, 1'b1, pend_r <= CW'(QUEUE_DEPTH + 1))

endmodule

bind point_in_triangle_table_unit pitt_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_pitt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire

FILE: tb/sv/point_in_triangle_table_unit_test.sv
// Self-checking testbench for the point-in-triangle table unit: load and query stream with checks.
`timescale 1ns / 1ps

module point_in_triangle_table_unit_test;
  import pitt_pkg::*;

  localparam int     RANDOM_WORDS = 1150;
  localparam int     STALL_LIMIT  = 2000;
  localparam int     DRAIN_CYCLES = 32;
  localparam int     HOLD_AT      = 400;
  localparam int     STEADY_FROM  = 700;
  localparam int     STEADY_TO    = 850;
  localparam longint CMAX = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint CMIN = -(longint'(1) <<< (COORD_W - 1));

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  point_in_triangle_table_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copy of the triangle table: origin and the edge vectors u and v.
  longint tri_org_x [0:PITT_TRI_COUNT-1];
  longint tri_org_y [0:PITT_TRI_COUNT-1];
  longint tri_u_x   [0:PITT_TRI_COUNT-1];
  longint tri_u_y   [0:PITT_TRI_COUNT-1];
  longint tri_v_x   [0:PITT_TRI_COUNT-1];
  longint tri_v_y   [0:PITT_TRI_COUNT-1];

  // Vertices as the stimulus generator loaded them, used to aim query points.
  longint gen_ax [0:PITT_TRI_COUNT-1];
  longint gen_ay [0:PITT_TRI_COUNT-1];
  longint gen_bx [0:PITT_TRI_COUNT-1];
  longint gen_by [0:PITT_TRI_COUNT-1];
  longint gen_cx [0:PITT_TRI_COUNT-1];
  longint gen_cy [0:PITT_TRI_COUNT-1];
  bit     gen_loaded [0:PITT_TRI_COUNT-1];
  int     loaded_entries [$];

  in_word_t  queued_words [$];
  out_word_t expected_verdicts [$];

  int   word_total = 0;
  int   words_sent = 0;
  int   verdicts_seen = 0;
  int   bad_verdicts = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   idle_cycles = 0;
  logic hold_off = 1'b0;
  logic steady = 1'b0;
  logic [15:0] rx_pattern = '1;
  int   rx_count = 0;

  // Applies one word to the table copy and returns the verdict it must produce.
  function automatic out_word_t predict_verdict(input in_word_t w);
    out_word_t r;
    int        idx;
    longint    dx, dy, det, ca, cb, cg;
    r = '0;
    idx = int'(w.tri_index);
    if (idx >= PITT_TRI_COUNT) return r;
    if (w.operation == OP_LOAD) begin
      tri_org_x[idx] = longint'(w.vert_a_x);
      tri_org_y[idx] = longint'(w.vert_a_y);
      tri_u_x[idx] = longint'(w.vert_b_x) - longint'(w.vert_a_x);
      tri_u_y[idx] = longint'(w.vert_b_y) - longint'(w.vert_a_y);
      tri_v_x[idx] = longint'(w.vert_c_x) - longint'(w.vert_a_x);
      tri_v_y[idx] = longint'(w.vert_c_y) - longint'(w.vert_a_y);
    end else begin
      dx = longint'(w.point_x) - tri_org_x[idx];
      dy = longint'(w.point_y) - tri_org_y[idx];
      det = tri_u_x[idx] * tri_v_y[idx] - tri_u_y[idx] * tri_v_x[idx];
      ca = tri_v_y[idx] * dx - tri_v_x[idx] * dy;
      cb = tri_u_x[idx] * dy - tri_u_y[idx] * dx;
      cg = det - ca - cb;
      if (det == 0) begin
        r.degenerate = 1'b1;
      end else begin
        // Each scaled coefficient must be zero or share the sign of the determinant.
        r.inside_res = (ca == 0 || (ca < 0) == (det < 0)) &&
                       (cb == 0 || (cb < 0) == (det < 0)) &&
                       (cg == 0 || (cg < 0) == (det < 0));
      end
    end
    return r;
  endfunction

  function automatic longint rand_coord();
    coord_t c;
    c = coord_t'($urandom);
    return longint'(c);
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic longint near_coord(input longint center);
    longint span;
    case ($urandom_range(0, 3))
      0: span = 64;
      1: span = 4096;
      2: span = 262144;
      default: return rand_coord();
    endcase
    return clamp_coord(center + longint'($urandom_range(0, int'(2 * span))) - span);
  endfunction

  // Every field gets random content first so that unused fields toggle too.
  function automatic in_word_t noise_word();
    in_word_t w;
    w.operation = 1'($urandom_range(0, 1));
    w.tri_index = INDEX_W'($urandom_range(0, PITT_TRI_COUNT - 1));
    w.vert_a_x = coord_t'($urandom);
    w.vert_a_y = coord_t'($urandom);
    w.vert_b_x = coord_t'($urandom);
    w.vert_b_y = coord_t'($urandom);
    w.vert_c_x = coord_t'($urandom);
    w.vert_c_y = coord_t'($urandom);
    w.point_x = coord_t'($urandom);
    w.point_y = coord_t'($urandom);
    return w;
  endfunction

  task automatic queue_load(input int idx, input longint ax, input longint ay,
                            input longint bx, input longint by,
                            input longint cx, input longint cy);
    in_word_t w;
    w = noise_word();
    w.operation = OP_LOAD;
    w.tri_index = idx[INDEX_W-1:0];
    w.vert_a_x = coord_t'(ax);
    w.vert_a_y = coord_t'(ay);
    w.vert_b_x = coord_t'(bx);
    w.vert_b_y = coord_t'(by);
    w.vert_c_x = coord_t'(cx);
    w.vert_c_y = coord_t'(cy);
    queued_words.push_back(w);
    gen_ax[idx] = ax; gen_ay[idx] = ay;
    gen_bx[idx] = bx; gen_by[idx] = by;
    gen_cx[idx] = cx; gen_cy[idx] = cy;
    if (!gen_loaded[idx]) begin
      gen_loaded[idx] = 1'b1;
      loaded_entries.push_back(idx);
    end
  endtask

  task automatic queue_query(input int idx, input longint px, input longint py);
    in_word_t w;
    w = noise_word();
    w.operation = OP_QUERY;
    w.tri_index = idx[INDEX_W-1:0];
    w.point_x = coord_t'(px);
    w.point_y = coord_t'(py);
    queued_words.push_back(w);
  endtask

  // Mostly points inside or on the loaded triangle, some near it, some anywhere.
  task automatic choose_point(input int idx, output longint px, output longint py);
    longint s, t;
    int     mode;
    mode = $urandom_range(0, 9);
    if (mode <= 7) begin
      s = longint'($urandom_range(0, 256));
      t = (mode == 7) ? 256 - s : longint'($urandom_range(0, int'(256 - s)));
      if (mode == 6) begin
        s = ($urandom_range(0, 2) == 0) ? 256 : 0;
        t = (s == 0 && $urandom_range(0, 1) == 1) ? 256 : 0;
      end
      px = gen_ax[idx] + ((s * (gen_bx[idx] - gen_ax[idx]) +
                           t * (gen_cx[idx] - gen_ax[idx])) >>> 8);
      py = gen_ay[idx] + ((s * (gen_by[idx] - gen_ay[idx]) +
                           t * (gen_cy[idx] - gen_ay[idx])) >>> 8);
    end else if (mode == 8) begin
      px = near_coord(gen_ax[idx]);
      py = near_coord(gen_ay[idx]);
    end else begin
      px = rand_coord();
      py = rand_coord();
    end
  endtask

  task automatic note_bad_verdict(input string what, input out_word_t want,
                                  input out_word_t got);
    bad_verdicts++;
    if (bad_verdicts <= 10)
      $display("%0t: verdict %0d %s: expected %0b%0b, got %0b%0b (inside_res, degenerate)",
               $realtime, verdicts_seen, what, want.inside_res, want.degenerate,
               got.inside_res, got.degenerate);
  endtask

  // Sender: bursts of words from the queue with random gaps in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(predict_verdict(in_data));
        words_sent <= words_sent + 1;
      end
      if (in_valid && !in_ready) begin
        // The offered word stays put until it is taken.
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (hold_off || queued_words.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_data <= queued_words.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: out_ready follows a rotating stall pattern that is redrawn now and then, and is held high while steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if (rx_count == 0) begin
      case ($urandom_range(0, 3))
        0: rx_pattern <= '1;
        1: rx_pattern <= 16'($urandom | $urandom);
        2: rx_pattern <= 16'($urandom);
        default: rx_pattern <= 16'($urandom & $urandom);
      endcase
      rx_count <= 47;
      out_ready <= 1'b1;
    end else begin
      out_ready <= rx_pattern[0];
      rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
      rx_count <= rx_count - 1;
    end
  end

  // Result checker: every accepted result word is matched against the oldest verdict.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        note_bad_verdict("with nothing pending", '0, out_data);
      end else if (out_data.inside_res !== expected_verdicts[0].inside_res ||
                   out_data.degenerate !== expected_verdicts[0].degenerate) begin
        note_bad_verdict("mismatch", expected_verdicts[0], out_data);
        void'(expected_verdicts.pop_front());
      end else begin
        void'(expected_verdicts.pop_front());
      end
      verdicts_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int     n, idx;
    longint ax, ay, bx, by, cx, cy, px, py;

    // Corner triangles that span the whole coordinate range.
    queue_load(0, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
    queue_query(0, CMIN, CMIN);
    queue_query(0, CMAX, CMAX);
    queue_query(0, -1, 0);
    queue_query(0, CMAX, CMIN);
    queue_load(PITT_TRI_COUNT - 1, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
    queue_query(PITT_TRI_COUNT - 1, CMIN, CMIN);
    queue_query(PITT_TRI_COUNT - 1, 0, 0);
    queue_query(PITT_TRI_COUNT - 1, CMAX, CMAX);
    // Degenerate entries: a single point and three collinear vertices.
    queue_load(1, 0, 0, 0, 0, 0, 0);
    queue_query(1, 0, 0);
    queue_load(2, CMIN, CMIN, 0, 0, CMAX, CMAX);
    queue_query(2, 5, 5);
    // Clockwise and counterclockwise winding, inside, on an edge and outside.
    queue_load(3, 0, 0, 0, 256, 256, 0);
    queue_query(3, 64, 64);
    queue_query(3, 128, 128);
    queue_query(3, 256, 256);
    queue_query(3, -1, 0);
    queue_load(4, 0, 0, 256, 0, 0, 256);
    queue_query(4, 1, 1);
    queue_query(4, 257, 0);
    // Overwriting an entry replaces the old triangle.
    queue_load(3, 1000, 1000, 1000, 2000, 2000, 1000);
    queue_query(3, 64, 64);
    queue_query(3, 1200, 1200);
    queue_query(4, CMIN, CMAX);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 9) < 3) begin
        idx = $urandom_range(0, PITT_TRI_COUNT - 1);
        ax = rand_coord();
        ay = rand_coord();
        bx = near_coord(ax);
        by = near_coord(ay);
        cx = near_coord(ax);
        cy = near_coord(ay);
        if ($urandom_range(0, 19) == 0) begin
          cx = bx;
          cy = by;
        end else if ($urandom_range(0, 19) == 0) begin
          bx = ax; by = ay; cx = ax; cy = ay;
        end
        queue_load(idx, ax, ay, bx, by, cx, cy);
      end else begin
        idx = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
        choose_point(idx, px, py);
        queue_query(idx, px, py);
      end
    end
    word_total = queued_words.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Stop sending once until every pending verdict has come back.
    while (words_sent < HOLD_AT) @(negedge clk);
    hold_off <= 1'b1;
    @(negedge clk);
    while (in_valid || expected_verdicts.size() != 0) @(negedge clk);
    hold_off <= 1'b0;

    // A stretch with no idling on either side.
    while (words_sent < STEADY_FROM) @(negedge clk);
    steady <= 1'b1;
    while (words_sent < STEADY_TO) @(negedge clk);
    steady <= 1'b0;

    while (words_sent < word_total || expected_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_verdicts == 0 && expected_verdicts.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pitt_pkg.sv
hdl/pitt_ram.sv
hdl/pitt_front.sv
hdl/pitt_fifo.sv
hdl/pitt_back.sv
hdl/point_in_triangle_table_unit.sv
hdl/pitt_checker.sv
tb/sv/point_in_triangle_table_unit_test.sv
